[hw/rtl/jmd_pkg.sv]
// Shared types and constants for the JPEG marker demultiplexer.
// Used by the parser, the result queue, the expander and the top level.
package jmd_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned HDR_BYTES  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_MAGIC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [1:0] CH_DATA  = 2'd0;
  localparam logic [1:0] CH_HUFF  = 2'd1;
  localparam logic [1:0] CH_QUANT = 2'd2;
  localparam logic [1:0] CH_NONE  = 2'd3;

  typedef struct packed {
    logic [1:0] channel;
    logic [7:0] value;
    logic       flush;
  } res_t;

  // Up to two explicit results, then optionally the eight frame header bytes.
  typedef struct packed {
    res_t       e0;
    res_t       e1;
    logic [1:0] n_exp;
    logic       hdr;
  } desc_t;

endpackage

[hw/rtl/jmd_parser.sv]
// Input register and marker/segment parser for the JPEG marker demultiplexer.
// Produces at most one result descriptor per byte, only for bytes that have results; depends on jmd_pkg.
module jmd_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_byte,
  input  logic          room,
  output logic          push,
  output jmd_pkg::desc_t push_desc
);
  import jmd_pkg::*;

  localparam logic [15:0] RECIP_65 = 16'd64528;
  localparam logic [6:0]  TABLE_LEN = 7'd64;

  typedef enum logic [3:0] {
    M_HUNT, M_MARK, M_SOF, M_DHT, M_DQT_HI, M_DQT_LO, M_DQT_BODY,
    M_SEG_HI, M_SEG_LO, M_SKIP, M_SOS
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic        ff_seen_r, ff_seen_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [9:0]  tables_left_r, tables_left_nxt;
  logic [6:0]  table_pos_r, table_pos_nxt;
  logic [7:0]  length_high_r, length_high_nxt;
  logic        in_vld_r;
  logic [7:0]  in_byte_r;

  mode_t       d_mode;
  logic        d_bytes_set;
  logic [15:0] d_bytes;
  logic        d_hdr;
  logic        d_eoi;

  logic        a_vld, b_vld, hdr;
  res_t        res_a, res_b;
  logic [15:0] len, len_m2, bytes_dec;
  logic [31:0] prod;
  logic [9:0]  tables_q, tables_dec;
  logic        adv, has_res;
  logic [1:0]  uch;

  // Marker dispatch decode
  always_comb begin
    d_mode      = M_HUNT;
    d_bytes_set = 1'b0;
    d_bytes     = '0;
    d_hdr       = 1'b0;
    d_eoi       = 1'b0;
    priority if (in_byte_r == 8'hc0) begin
      d_mode      = M_SOF;
      d_bytes_set = 1'b1;
      d_bytes     = 16'd10;
      d_hdr       = 1'b1;
    end else if (in_byte_r == 8'hc4) begin
      d_mode = M_DHT;
    end else if (in_byte_r == 8'hdb) begin
      d_mode = M_DQT_HI;
    end else if (in_byte_r == 8'hdd) begin
      d_mode      = M_SKIP;
      d_bytes_set = 1'b1;
      d_bytes     = 16'd4;
    end else if (in_byte_r == 8'hda) begin
      d_mode = M_SOS;
    end else if (in_byte_r == 8'hd9) begin
      d_mode = M_HUNT;
      d_eoi  = 1'b1;
    end else if (in_byte_r == 8'hfe || in_byte_r[7:4] == 4'he) begin
      d_mode = M_SEG_HI;
    end else if (in_byte_r[7:3] == 5'b11010) begin
      d_mode = M_MARK;
    end else begin
      d_mode = M_HUNT;
    end
  end

  assign len        = {length_high_r, in_byte_r};
  assign len_m2     = (len >= 16'd2) ? (len - 16'd2) : '0;
  assign prod       = len_m2 * RECIP_65;
  assign tables_q   = prod[31:22];
  assign bytes_dec  = bytes_left_r - 16'd1;
  assign tables_dec = tables_left_r - 10'd1;
  assign uch        = (mode_r == M_DHT) ? CH_HUFF : CH_DATA;

  always_comb begin
    mode_nxt        = mode_r;
    ff_seen_nxt     = ff_seen_r;
    bytes_left_nxt  = bytes_left_r;
    tables_left_nxt = tables_left_r;
    table_pos_nxt   = table_pos_r;
    length_high_nxt = length_high_r;
    a_vld = 1'b0;
    b_vld = 1'b0;
    hdr   = 1'b0;
    res_a = '{channel: CH_DATA, value: in_byte_r, flush: 1'b0};
    res_b = '{channel: CH_DATA, value: 8'h00, flush: 1'b1};
    unique case (mode_r)
      M_MARK: begin
        if (in_byte_r == 8'hff) begin
          ff_seen_nxt = 1'b1;
        end else if (in_byte_r != 8'h00 && ff_seen_r) begin
          ff_seen_nxt = 1'b0;
          mode_nxt    = d_mode;
          if (d_bytes_set) begin
            bytes_left_nxt = d_bytes;
          end
          hdr   = d_hdr;
          b_vld = d_eoi;
        end else begin
          ff_seen_nxt = 1'b0;
        end
      end
      M_SOF: begin
        a_vld          = (bytes_left_r == 16'd3);
        bytes_left_nxt = bytes_dec;
        if (bytes_dec == 16'd0) begin
          mode_nxt = M_MARK;
        end
      end
      M_DHT, M_SOS: begin
        res_a.channel = uch;
        if (ff_seen_r) begin
          ff_seen_nxt = 1'b0;
          if (in_byte_r == 8'h00) begin
            a_vld       = 1'b1;
            res_a.value = 8'hff;
          end else begin
            a_vld       = (mode_r == M_DHT);
            res_a.value = 8'h00;
            res_a.flush = 1'b1;
            mode_nxt    = d_mode;
            if (d_bytes_set) begin
              bytes_left_nxt = d_bytes;
            end
            hdr   = d_hdr;
            b_vld = d_eoi;
          end
        end else if (in_byte_r == 8'hff) begin
          ff_seen_nxt = 1'b1;
        end else begin
          a_vld = 1'b1;
        end
      end
      M_DQT_HI: begin
        length_high_nxt = in_byte_r;
        mode_nxt        = M_DQT_LO;
      end
      M_DQT_LO: begin
        tables_left_nxt = tables_q;
        table_pos_nxt   = '0;
        if (tables_q == 10'd0) begin
          a_vld    = 1'b1;
          res_a    = '{channel: CH_QUANT, value: 8'h00, flush: 1'b1};
          mode_nxt = M_MARK;
        end else begin
          mode_nxt = M_DQT_BODY;
        end
      end
      M_DQT_BODY: begin
        a_vld         = (table_pos_r != 7'd0);
        res_a.channel = CH_QUANT;
        res_b.channel = CH_QUANT;
        if (table_pos_r >= TABLE_LEN) begin
          table_pos_nxt   = '0;
          tables_left_nxt = tables_dec;
          if (tables_dec == 10'd0) begin
            b_vld    = 1'b1;
            mode_nxt = M_MARK;
          end
        end else begin
          table_pos_nxt = table_pos_r + 7'd1;
        end
      end
      M_SEG_HI: begin
        length_high_nxt = in_byte_r;
        mode_nxt        = M_SEG_LO;
      end
      M_SEG_LO: begin
        bytes_left_nxt = len_m2;
        mode_nxt       = (len_m2 != 16'd0) ? M_SKIP : M_MARK;
      end
      M_SKIP: begin
        bytes_left_nxt = bytes_dec;
        if (bytes_dec == 16'd0) begin
          mode_nxt = M_MARK;
        end
      end
      default: begin
        if (in_byte_r == 8'hff) begin
          ff_seen_nxt = 1'b1;
          mode_nxt    = M_HUNT;
        end else if (in_byte_r != 8'h00 && ff_seen_r) begin
          ff_seen_nxt = 1'b0;
          mode_nxt    = (in_byte_r == 8'hd8) ? M_MARK : M_HUNT;
        end else begin
          ff_seen_nxt = 1'b0;
          mode_nxt    = M_HUNT;
        end
      end
    endcase
  end

  always_comb begin
    push_desc     = '0;
    push_desc.hdr = hdr;
    if (a_vld) begin
      push_desc.e0    = res_a;
      push_desc.e1    = res_b;
      push_desc.n_exp = b_vld ? 2'd2 : 2'd1;
    end else begin
      push_desc.e0    = res_b;
      push_desc.n_exp = b_vld ? 2'd1 : 2'd0;
    end
  end

  assign has_res  = a_vld | b_vld | hdr;
  assign adv      = in_vld_r & (room | ~has_res);
  assign push     = adv & has_res;
  assign in_stall = in_vld_r & ~adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      mode_r        <= M_HUNT;
      ff_seen_r     <= 1'b0;
      bytes_left_r  <= '0;
      tables_left_r <= '0;
      table_pos_r   <= '0;
      length_high_r <= '0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        mode_r        <= mode_nxt;
        ff_seen_r     <= ff_seen_nxt;
        bytes_left_r  <= bytes_left_nxt;
        tables_left_r <= tables_left_nxt;
        table_pos_r   <= table_pos_nxt;
        length_high_r <= length_high_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_byte;
    end
  end

endmodule

[hw/rtl/jmd_queue.sv]
// Small descriptor queue between the parser and the result expander.
// Depends on jmd_pkg for the descriptor type and depth.
module jmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  jmd_pkg::desc_t push_desc,
  output logic           room,
  input  logic           pop,
  output logic           head_vld,
  output jmd_pkg::desc_t head
);
  import jmd_pkg::*;

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);

  desc_t            mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign head_vld = (cnt_r != '0);
  assign head     = mem_r[rd_ptr_r];
  assign room     = (cnt_r != CNT_FULL) | pop;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

[hw/rtl/jmd_expand.sv]
// Result expander and output register: walks one descriptor, one item per cycle
// unless the output stalls. Reads the frame header registers; depends on jmd_pkg.
module jmd_expand (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_vld,
  input  jmd_pkg::desc_t head,
  output logic           pop,
  input  logic [31:0]    frame_magic,
  input  logic [15:0]    frame_width,
  input  logic [15:0]    frame_height,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     out_channel,
  output logic [7:0]     out_value,
  output logic           out_flush,
  output logic           out_last
);
  import jmd_pkg::*;

  logic [3:0]  cursor_r;
  logic        out_vld_r;
  res_t        out_res_r;
  logic        out_last_r;

  logic [3:0]  total, hdr_off;
  logic [2:0]  hdr_sel;
  logic [63:0] hdr_word;
  logic        load, is_last;
  res_t        sel_res;

  assign total    = {2'b00, head.n_exp} + (head.hdr ? 4'(HDR_BYTES) : 4'd0);
  assign is_last  = (cursor_r == total - 4'd1);
  assign load     = head_vld & (~out_vld_r | ~out_stall);
  assign pop      = load & is_last;
  assign hdr_off  = cursor_r - {2'b00, head.n_exp};
  assign hdr_sel  = 3'd7 - hdr_off[2:0];
  assign hdr_word = {frame_magic, frame_width, frame_height};

  always_comb begin
    if (cursor_r < {2'b00, head.n_exp}) begin
      sel_res = cursor_r[0] ? head.e1 : head.e0;
    end else begin
      sel_res = '{channel: CH_DATA, value: hdr_word[{hdr_sel, 3'b000} +: 8], flush: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (load) begin
        out_vld_r <= 1'b1;
        cursor_r  <= is_last ? 4'd0 : cursor_r + 4'd1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r  <= sel_res;
      out_last_r <= is_last;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_channel = out_res_r.channel;
  assign out_value   = out_res_r.value;
  assign out_flush   = out_res_r.flush;
  assign out_last    = out_last_r;

endmodule

[hw/rtl/jpeg_marker_demux.sv]
// Top level of the JPEG marker demultiplexer: configuration registers and assertions.
// Instantiates jmd_parser, jmd_queue and jmd_expand; depends on jmd_pkg.
//
//   port group  dir  handshake          payload
//   in_*        in   in_valid/in_stall  in_byte
//   out_*       out  out_valid/out_stall out_channel, out_value, out_flush, out_last
//   cfg_*       in   cfg_wr_en          cfg_index, cfg_data
//
// One byte is accepted per cycle unless in_stall; its results pass through the input
// register, the descriptor queue and the output register, one per cycle unless out_stall.
// A byte yields up to nine results (a Huffman flush and the frame header); the bytes after
// such a burst carry few results, so without output stalls the input never stalls.
// Reset is synchronous, active low, and clears parser state and the descriptor queue.
// A stalled output holds its item; input stalls while the two-entry descriptor queue is
// full and not being popped, and the byte in the input register has results.
module jpeg_marker_demux (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_channel,
  output logic [7:0]  out_value,
  output logic        out_flush,
  output logic        out_last,
  input  logic        cfg_wr_en,
  input  logic [jmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jmd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import jmd_pkg::*;

  logic [31:0] frame_magic_r;
  logic [15:0] frame_width_r;
  logic [15:0] frame_height_r;

  logic  push, room, pop, head_vld;
  desc_t push_desc, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_magic_r  <= '0;
      frame_width_r  <= '0;
      frame_height_r <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_FRAME_MAGIC) begin
        frame_magic_r <= cfg_data[31:0];
      end
      if (cfg_index == REG_FRAME_WIDTH) begin
        frame_width_r <= cfg_data[15:0];
      end
      if (cfg_index == REG_FRAME_HEIGHT) begin
        frame_height_r <= cfg_data[15:0];
      end
    end
  end

  jmd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .room      (room),
    .push      (push),
    .push_desc (push_desc)
  );

  jmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .room      (room),
    .pop       (pop),
    .head_vld  (head_vld),
    .head      (head)
  );

  jmd_expand u_expand (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_vld     (head_vld),
    .head         (head),
    .pop          (pop),
    .frame_magic  (frame_magic_r),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_channel  (out_channel),
    .out_value    (out_value),
    .out_flush    (out_flush),
    .out_last     (out_last)
  );

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n) push |-> room)
    else $error("descriptor pushed into a full queue");

  a_pop_vld: assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_vld)
    else $error("descriptor popped from an empty queue");

  a_flush_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_flush |-> out_value == 8'h00)
    else $error("flush item carries a non-zero byte");

  a_channel_ok: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> out_channel != CH_NONE)
    else $error("item routed to an unused channel");

endmodule
